[hw/rtl/scf_pkg.sv]
package scf_pkg;

  localparam logic [7:0] SofByte = 8'hFD;
  localparam logic [7:0] TailA   = 8'h0A;
  localparam logic [7:0] TailB   = 8'h05;
  localparam logic [8:0] LenExtra = 9'd6;
  localparam logic [7:0] CountMax = 8'hFF;

  localparam logic [7:0] CmdReset    = 8'd1;
  localparam logic [7:0] ParamReset  = 8'd0;
  localparam logic [7:0] MaxLenReset = 8'd220;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatBadSize  = 2'd1;
  localparam logic [1:0] StatMismatch = 2'd2;

  localparam logic [1:0] RegCmd    = 2'd0;
  localparam logic [1:0] RegParam  = 2'd1;
  localparam logic [1:0] RegMaxLen = 2'd2;

  // slots 0..7 header, then text byte, then checksum / error result
  localparam logic [3:0] SlotSof    = 4'd0;
  localparam logic [3:0] SlotLenHi  = 4'd1;
  localparam logic [3:0] SlotLenLo  = 4'd2;
  localparam logic [3:0] SlotCmd    = 4'd3;
  localparam logic [3:0] SlotParam  = 4'd4;
  localparam logic [3:0] SlotTailA  = 4'd5;
  localparam logic [3:0] SlotTailB  = 4'd6;
  localparam logic [3:0] SlotTailC  = 4'd7;
  localparam logic [3:0] SlotText   = 4'd8;
  localparam logic [3:0] SlotChk    = 4'd9;

  typedef struct packed {
    logic [3:0] first;
    logic [3:0] last;
    logic       len_hi;
    logic [7:0] len_lo;
    logic [7:0] cmd;
    logic [7:0] param;
    logic [7:0] text;
    logic [7:0] chk;
    logic [1:0] status;
  } scf_job_t;

endpackage

[hw/rtl/scf_text_if.sv]
interface scf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic [7:0] message_len;
  logic       byte_last;

  modport source (output valid, output text_byte, output message_len, output byte_last,
                  input ready);
  modport sink (input valid, input text_byte, input message_len, input byte_last,
                output ready);
endinterface

[hw/rtl/scf_frame_if.sv]
interface scf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  logic [1:0] frame_status;

  modport source (output valid, output frame_byte, output frame_last, output frame_status,
                  input ready);
  modport sink (input valid, input frame_byte, input frame_last, input frame_status,
                output ready);
endinterface

[hw/rtl/scf_emit.sv]
module scf_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_load_i,
  input  scf_pkg::scf_job_t job_i,
  output logic             job_free_o,
  scf_frame_if.source      frame_o
);
  import scf_pkg::*;

  logic       job_valid_q, job_valid_d;
  scf_job_t   job_q;
  logic [3:0] slot_q, slot_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [1:0] status_q, status_d;
  logic       advance, finish;

  assign advance    = job_valid_q && (!out_valid_q || frame_o.ready);
  assign finish     = advance && (slot_q == job_q.last);
  assign job_free_o = !job_valid_q || finish;

  always_comb begin
    byte_d   = job_q.text;
    last_d   = 1'b0;
    status_d = StatOk;
    unique case (slot_q)
      SlotSof:   byte_d = SofByte;
      SlotLenHi: byte_d = {7'd0, job_q.len_hi};
      SlotLenLo: byte_d = job_q.len_lo;
      SlotCmd:   byte_d = job_q.cmd;
      SlotParam: byte_d = job_q.param;
      SlotTailA: byte_d = TailA;
      SlotTailB: byte_d = TailB;
      SlotTailC: byte_d = TailB;
      SlotText:  byte_d = job_q.text;
      SlotChk: begin
        byte_d   = job_q.chk;
        last_d   = 1'b1;
        status_d = job_q.status;
      end
      default:   byte_d = job_q.text;
    endcase
  end

  always_comb begin
    job_valid_d = job_valid_q;
    slot_d      = slot_q;
    if (advance) begin
      slot_d = slot_q + 4'd1;
      if (finish) job_valid_d = 1'b0;
    end
    if (job_load_i) begin
      job_valid_d = 1'b1;
      slot_d      = job_i.first;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      slot_q      <= SlotSof;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) job_q <= job_i;
    if (advance) begin
      byte_q   <= byte_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign frame_o.valid        = out_valid_q;
  assign frame_o.frame_byte   = byte_q;
  assign frame_o.frame_last   = last_q;
  assign frame_o.frame_status = status_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (slot_q <= job_q.last))
    else $error("slot past end of job");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("output register not filled after advance");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> job_free_o)
    else $error("job loaded while busy");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (status_q == StatOk))
    else $error("status on a data item");

endmodule

[hw/rtl/speech_command_framer.sv]
// channel  | dir | handshake     | payload
// text_i   | in  | valid / ready | text_byte, message_len, byte_last
// frame_o  | out | valid / ready | frame_byte, frame_last, frame_status
// cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// Each item is decoded in the cycle it is accepted; the emitter then sends one result
// per cycle unless stalled, from its slot counter: 10 results for a first byte marked
// last, 9 for a first byte, 2 for a later last byte, 1 for others or errors, 0 if dropped.
// The next item is accepted in the cycle the current job's final result is registered.
// A full output register stalls the emitter; reset clears all control state.
module speech_command_framer (
  input  logic       clk_i,
  input  logic       rst_ni,
  scf_text_if.sink   text_i,
  scf_frame_if.source frame_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import scf_pkg::*;

  logic [7:0] cmd_q, param_q, max_len_q;
  logic       in_msg_q, in_msg_d;
  logic       drop_q, drop_d;
  logic [7:0] exp_q, exp_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;

  logic       accept, first, bad, job_load, job_free;
  logic [8:0] total;
  logic [7:0] hdr_xor;
  scf_job_t   job;

  assign accept = text_i.valid && text_i.ready;
  assign first  = !in_msg_q;
  assign bad    = (text_i.message_len == 8'd0) || (text_i.message_len > max_len_q);
  assign total  = {1'b0, text_i.message_len} + LenExtra;
  assign hdr_xor = SofByte ^ {7'd0, total[8]} ^ total[7:0] ^ cmd_q ^ param_q ^ TailA;

  always_comb begin
    in_msg_d = in_msg_q;
    drop_d   = drop_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    job_load = 1'b0;

    job.first  = SlotText;
    job.last   = text_i.byte_last ? SlotChk : SlotText;
    job.len_hi = total[8];
    job.len_lo = total[7:0];
    job.cmd    = cmd_q;
    job.param  = param_q;
    job.text   = text_i.text_byte;
    job.chk    = 8'd0;
    job.status = StatOk;

    if (first) begin
      exp_d = text_i.message_len;
      cnt_d = 8'd1;
      xor_d = hdr_xor ^ text_i.text_byte;
    end else begin
      cnt_d = (cnt_q == CountMax) ? CountMax : cnt_q + 8'd1;
      xor_d = xor_q ^ text_i.text_byte;
    end
    job.chk    = xor_d;
    job.status = (cnt_d != exp_d) ? StatMismatch : StatOk;
    if (first) job.first = SlotSof;

    if (!accept) begin
      exp_d = exp_q;
      cnt_d = cnt_q;
      xor_d = xor_q;
    end else if (drop_q) begin
      exp_d = exp_q;
      cnt_d = cnt_q;
      xor_d = xor_q;
      if (text_i.byte_last) drop_d = 1'b0;
    end else if (first && bad) begin
      exp_d      = exp_q;
      cnt_d      = cnt_q;
      xor_d      = xor_q;
      drop_d     = !text_i.byte_last;
      job_load   = 1'b1;
      job.first  = SlotChk;
      job.last   = SlotChk;
      job.chk    = 8'd0;
      job.status = StatBadSize;
    end else begin
      job_load = 1'b1;
      in_msg_d = !text_i.byte_last;
    end
  end

  assign text_i.ready = job_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= CmdReset;
      param_q   <= ParamReset;
      max_len_q <= MaxLenReset;
      in_msg_q  <= 1'b0;
      drop_q    <= 1'b0;
      exp_q     <= 8'd0;
      cnt_q     <= 8'd0;
      xor_q     <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegCmd:    cmd_q     <= cfg_data_i;
          RegParam:  param_q   <= cfg_data_i;
          RegMaxLen: max_len_q <= cfg_data_i;
          default:   ;
        endcase
      end
      in_msg_q <= in_msg_d;
      drop_q   <= drop_d;
      exp_q    <= exp_d;
      cnt_q    <= cnt_d;
      xor_q    <= xor_d;
    end
  end

  scf_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_load_i (job_load),
    .job_i      (job),
    .job_free_o (job_free),
    .frame_o    (frame_o)
  );

  a_drop_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> !in_msg_q)
    else $error("dropping while a frame is open");

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load |-> (accept && !drop_q))
    else $error("job without an accepted item");

endmodule

[bench/tb.sv]
module tb;
  import scf_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int TailWait    = 12;
  localparam int HoldCycles  = 80;
  localparam int RandomItems = 100;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } frame_t;

  class frame_tracker;
    logic [7:0] cmd_code;
    logic [7:0] cmd_param;
    logic [7:0] max_len;
    bit         open_msg;
    bit         skipping;
    logic [7:0] announced;
    logic [7:0] seen;
    logic [7:0] chk;
    frame_t     due[$];
    int         errors;
    int         framed_items;

    function new();
      cmd_code     = CmdReset;
      cmd_param    = ParamReset;
      max_len      = MaxLenReset;
      open_msg     = 1'b0;
      skipping     = 1'b0;
      announced    = '0;
      seen         = '0;
      chk          = '0;
      errors       = 0;
      framed_items = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        RegCmd:    cmd_code = val;
        RegParam:  cmd_param = val;
        RegMaxLen: max_len = val;
        default: ;
      endcase
    endfunction

    function void emit_data(logic [7:0] b);
      chk = chk ^ b;
      due.push_back('{data: b, last: 1'b0, status: StatOk});
    endfunction

    function void take_text(logic [7:0] tb_byte, logic [7:0] len, logic last);
      logic [8:0] total;
      if (skipping) begin
        if (last) skipping = 1'b0;
        return;
      end
      framed_items++;
      if (!open_msg) begin
        if (len == 8'd0 || len > max_len) begin
          due.push_back('{data: 8'h00, last: 1'b1, status: StatBadSize});
          if (!last) skipping = 1'b1;
          return;
        end
        total     = {1'b0, len} + LenExtra;
        chk       = '0;
        announced = len;
        seen      = '0;
        emit_data(SofByte);
        emit_data({7'd0, total[8]});
        emit_data(total[7:0]);
        emit_data(cmd_code);
        emit_data(cmd_param);
        emit_data(TailA);
        emit_data(TailB);
        emit_data(TailB);
        open_msg = 1'b1;
      end
      emit_data(tb_byte);
      if (seen != CountMax) seen++;
      if (last) begin
        due.push_back('{data: chk, last: 1'b1,
                        status: (seen != announced) ? StatMismatch : StatOk});
        open_msg = 1'b0;
      end
    endfunction

    function void check_frame(logic [7:0] data, logic last, logic [1:0] status);
      frame_t want;
      if (due.size() == 0) begin
        $error("frame item with none expected: byte %0h last %0b status %0d",
               data, last, status);
        errors++;
        return;
      end
      want = due.pop_front();
      if (data !== want.data) begin
        $error("frame_byte: expected %0h, got %0h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
      if (status !== want.status) begin
        $error("frame_status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  scf_text_if  text_ch();
  scf_frame_if frame_ch();

  speech_command_framer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_i     (text_ch),
    .frame_o    (frame_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  frame_tracker tracker = new();

  always #4 clk_i = ~clk_i;

  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.set_reg(cfg_idx_i, cfg_data_i);
      if (text_ch.valid && text_ch.ready)
        tracker.take_text(text_ch.text_byte, text_ch.message_len, text_ch.byte_last);
      if (frame_ch.valid && frame_ch.ready)
        tracker.check_frame(frame_ch.frame_byte, frame_ch.frame_last, frame_ch.frame_status);
    end
  end

  // receiver: stall pattern per phase, plus an occasional long hold-off
  int stall_mode = 0;
  int hold_req = 0;
  int hold_left = 0;
  int rx_tick = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      frame_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      frame_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: frame_ch.ready <= 1'b1;
        1: frame_ch.ready <= ($urandom_range(0, 3) != 0);
        2: frame_ch.ready <= ((rx_tick % 7) < 4);
        default: frame_ch.ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
    rx_tick++;
  end

  bit gaps_on = 1'b0;
  int burst_left = 0;
  int cur_max = MaxLenReset;

  task automatic push_text(input logic [7:0] b, input logic [7:0] len, input logic last);
    if (gaps_on && burst_left == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= b;
    text_ch.message_len <= len;
    text_ch.byte_last   <= last;
    do @(posedge clk_i); while (!text_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_msg(input logic [7:0] len, input int count);
    for (int i = 0; i < count; i++) push_text(8'($urandom), len, i == count - 1);
  endtask

  task automatic drain_frames();
    text_ch.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_max(input logic [7:0] val);
    write_reg(RegMaxLen, val);
    cur_max = val;
  endtask

  initial begin
    int start;
    int kind;
    int lim;
    int n;
    logic [7:0] len;

    text_ch.valid       = 1'b0;
    text_ch.text_byte   = '0;
    text_ch.message_len = '0;
    text_ch.byte_last   = 1'b0;
    frame_ch.ready      = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = RegCmd;
    cfg_data_i          = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset settings
    push_text(8'hFF, 8'd1, 1'b1);
    push_text(8'h00, 8'd3, 1'b0);
    push_text(8'hA5, 8'd3, 1'b0);
    push_text(8'h5A, 8'd3, 1'b1);
    push_text(8'h12, 8'd0, 1'b1);
    push_text(8'h34, 8'd221, 1'b0);
    push_text(8'h56, 8'd221, 1'b0);
    push_text(8'h78, 8'd221, 1'b1);
    push_text(8'h9C, 8'd4, 1'b0);
    push_text(8'h3E, 8'd4, 1'b1);
    push_text(8'h01, 8'd2, 1'b0);
    push_text(8'h80, 8'd2, 1'b0);
    push_text(8'h7F, 8'd2, 1'b1);
    push_text(8'hC3, 8'd220, 1'b1);
    push_text(8'hAA, 8'd255, 1'b1);
    drain_frames();

    write_reg(RegCmd, 8'hFF);
    write_reg(RegParam, 8'hFF);
    set_max(8'd249);
    write_reg(RegUnused, 8'h00);
    push_text(8'h55, 8'd249, 1'b1);
    push_text(8'h66, 8'd250, 1'b1);
    drain_frames();

    set_max(8'd0);
    push_text(8'h11, 8'd1, 1'b1);
    drain_frames();

    set_max(8'd1);
    push_text(8'h22, 8'd1, 1'b1);
    push_text(8'h33, 8'd2, 1'b0);
    push_text(8'h44, 8'd2, 1'b1);
    drain_frames();

    // long receiver hold-off while the sender keeps offering
    write_reg(RegCmd, 8'h00);
    write_reg(RegParam, 8'h00);
    set_max(MaxLenReset);
    stall_mode = 1;
    hold_req = HoldCycles;
    send_msg(8'd40, 40);
    drain_frames();

    // count saturates: 257 bytes against an announced 255 is not a mismatch
    set_max(8'hFF);
    stall_mode = 0;
    gaps_on = 1'b1;
    send_msg(8'd255, 257);
    drain_frames();

    start = tracker.framed_items;
    while (tracker.framed_items - start < RandomItems) begin
      write_reg(RegCmd, 8'($urandom));
      write_reg(RegParam, 8'($urandom));
      case ($urandom_range(0, 5))
        0: set_max(8'd1);
        1: set_max(8'd249);
        2: set_max(MaxLenReset);
        default: set_max(8'($urandom_range(1, 249)));
      endcase
      stall_mode = $urandom_range(0, 3);
      gaps_on = $urandom_range(0, 1);
      if ($urandom_range(0, 3) == 0) hold_req = HoldCycles;
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 19);
        lim = (kind == 0) ? 60 : 16;
        if (lim > cur_max) lim = cur_max;
        if (kind < 13) begin
          len = 8'($urandom_range(1, lim));
          send_msg(len, len);
        end else if (kind < 16) begin
          len = 8'($urandom_range(1, lim));
          if (len > 1 && $urandom_range(0, 1) == 1) n = $urandom_range(1, len - 1);
          else n = len + $urandom_range(1, 3);
          send_msg(len, n);
        end else if (kind < 18) begin
          if (cur_max >= 255 || $urandom_range(0, 1) == 1) len = 8'd0;
          else len = 8'($urandom_range(cur_max + 1, 255));
          send_msg(len, $urandom_range(1, 4));
        end else begin
          repeat ($urandom_range(1, 3))
            push_text(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        end
      end
      drain_frames();
    end

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
